>>> hw/rtl/ladj_pkg.sv
// Package for the lower-to-full adjacency builder: sizes, codes and payload types.
// Used by every module in hw/rtl.
package ladj_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_ENTRIES = 8192;
  localparam int NW = 11;
  localparam int VW = 14;
  localparam int PA = 11;
  localparam int AA = 13;

  localparam logic [2:0] REQ_NODE  = 3'd0;
  localparam logic [2:0] REQ_NBR   = 3'd1;
  localparam logic [2:0] REQ_FIN   = 3'd2;
  localparam logic [2:0] REQ_RDPTR = 3'd3;
  localparam logic [2:0] REQ_RDADJ = 3'd4;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  lower_degree;
    logic [9:0]  total_degree;
    logic [10:0] neighbor;
    logic [13:0] index;
  } req_t;

  typedef struct packed {
    logic [13:0] value;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_NODE, OP_NBR, OP_FIN, OP_RDPTR, OP_RDADJ, OP_STAT
  } op_e;

  // Classified command handed from front to back.
  typedef struct packed {
    op_e         op;
    logic [1:0]  status;
    logic [9:0]  lower_degree;
    logic [9:0]  total_degree;
    logic [10:0] neighbor;
    logic [13:0] index;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_NBR_RD, S_NBR_WR, S_FIN_RD, S_FIN_WR, S_RD_WAIT
  } bstate_e;

endpackage

>>> hw/rtl/ladj_front.sv
// Front end: accepts requests, checks sequencing and ranges, tracks node and
// neighbour counts. Depends on ladj_pkg.
module ladj_front import ladj_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  req_t        req,
  input  logic [10:0] node_count,
  input  logic        dec_undo,
  output cmd_t        cmd
);

  logic [10:0] current_node;
  logic [9:0]  neighbors_left;
  logic [13:0] next_row_start;
  logic        built;
  logic [10:0] n_eff;
  logic [14:0] row_end;

  assign n_eff = (node_count > 11'(MAX_NODES)) ? 11'(MAX_NODES) : node_count;
  assign row_end = {1'b0, next_row_start} + {5'd0, req.total_degree};

  always_comb begin
    cmd = '{op: OP_STAT, status: ST_ERR, lower_degree: req.lower_degree,
            total_degree: req.total_degree, neighbor: req.neighbor, index: req.index};
    case (req.req_type)
      REQ_NODE: begin
        if (n_eff == '0 || built || neighbors_left != '0 || current_node >= n_eff ||
            req.lower_degree > req.total_degree)
          cmd.status = ST_ERR;
        else if (row_end > 15'(MAX_ENTRIES + 1))
          cmd.status = ST_OVF;
        else
          cmd.op = OP_NODE;
      end
      REQ_NBR: begin
        if (!(neighbors_left == '0 || req.neighbor == '0 || req.neighbor >= current_node))
          cmd.op = OP_NBR;
      end
      REQ_FIN: begin
        if (n_eff == '0)
          cmd.status = ST_DONE;
        else if (!(built || current_node != n_eff || neighbors_left != '0))
          cmd.op = OP_FIN;
      end
      REQ_RDPTR: begin
        if (req.index != '0 && req.index <= 14'(MAX_NODES + 1)) cmd.op = OP_RDPTR;
      end
      REQ_RDADJ: begin
        if (req.index != '0 && req.index <= 14'(MAX_ENTRIES)) cmd.op = OP_RDADJ;
      end
      default: cmd.status = ST_ERR;
    endcase
  end

  // The front counts down the neighbours as they are taken; when the back end finds an
  // overflow it reports an undo and the count goes back up.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_node   <= '0;
      neighbors_left <= '0;
      next_row_start <= 14'd1;
      built          <= 1'b0;
    end else if (take) begin
      if (cmd.op == OP_NODE) begin
        current_node   <= current_node + 11'd1;
        neighbors_left <= req.lower_degree;
        next_row_start <= row_end[13:0];
      end else if (cmd.op == OP_NBR) begin
        neighbors_left <= neighbors_left - 10'd1;
      end else if (cmd.op == OP_FIN) begin
        built <= 1'b1;
      end
    end else if (dec_undo) begin
      neighbors_left <= neighbors_left + 10'd1;
    end
  end

endmodule

>>> hw/rtl/ladj_back.sv
// Back end: executes classified commands on the pointer and adjacency memories.
// Depends on ladj_pkg.
module ladj_back import ladj_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  input  logic [10:0] node_count,
  output logic        cmd_take,
  output logic        rsp_valid,
  output rsp_t        rsp,
  output logic        ovf_undo,
  output logic        idle
);

  logic [VW-1:0] ptr_mem [0:MAX_NODES];
  logic [NW-1:0] adj_mem [0:MAX_ENTRIES-1];

  bstate_e state, state_next;
  cmd_t    cur;
  logic [10:0] current_node;
  logic [13:0] fill_position;
  logic [10:0] k;
  logic [VW-1:0] ptr_q;
  logic [NW-1:0] adj_q;
  logic rd_is_ptr;

  logic        ptr_we, adj_we, adj_we2;
  logic [PA-1:0] ptr_wa, ptr_ra;
  logic [VW-1:0] ptr_wd;
  logic [AA-1:0] adj_wa, adj_wa2, adj_ra;
  logic [NW-1:0] adj_wd, adj_wd2;
  logic [14:0] slot;
  logic [10:0] n_eff;
  logic [VW-1:0] ptr_row_start;
  logic [13:0] next_row_start;

  assign n_eff = (node_count > 11'(MAX_NODES)) ? 11'(MAX_NODES) : node_count;
  assign slot  = {1'b0, ptr_q} + 15'd1;
  assign idle  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[ptr_wa] <= ptr_wd;
    ptr_q <= ptr_mem[ptr_ra];
  end
  // Up to two writes per neighbour go in successive cycles through one port.
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    else if (adj_we2) adj_mem[adj_wa2] <= adj_wd2;
    adj_q <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      current_node <= '0;
      fill_position <= 14'd1;
      k <= '0;
    end else begin
      state <= state_next;
      if (cmd_take) begin
        cur <= cmd;
        if (cmd.op == OP_NODE) current_node <= current_node + 11'd1;
        if (cmd.op == OP_FIN) k <= n_eff;
        rd_is_ptr <= (cmd.op == OP_RDPTR);
      end
      if (ptr_we && state == S_IDLE) fill_position <= ptr_row_start;
      if (state == S_NBR_WR && slot <= 15'(MAX_ENTRIES)) fill_position <= fill_position + 14'd1;
      if (state == S_FIN_WR) k <= k - 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) next_row_start <= 14'd1;
    else if (cmd_take && cmd.op == OP_NODE)
      next_row_start <= next_row_start + {4'd0, cmd.total_degree};
  end
  assign ptr_row_start = next_row_start;

  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    rsp_valid = 1'b0;
    rsp = '{value: '0, status: ST_ERR};
    ovf_undo = 1'b0;
    ptr_we = 1'b0; ptr_wa = '0; ptr_wd = '0; ptr_ra = '0;
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0;
    adj_we2 = 1'b0; adj_wa2 = '0; adj_wd2 = '0; adj_ra = '0;
    case (state)
      S_IDLE: begin
        cmd_take = cmd_valid;
        ptr_ra = PA'(cmd.neighbor - 11'd1);
        adj_ra = AA'(cmd.index - 14'd1);
        if (cmd.op == OP_RDPTR) ptr_ra = PA'(cmd.index - 14'd1);
        if (cmd_valid) begin
          case (cmd.op)
            OP_NODE: begin
              ptr_we = 1'b1;
              ptr_wa = PA'(current_node);
              ptr_wd = next_row_start + {4'd0, cmd.lower_degree} - 14'd1;
            end
            OP_NBR:   state_next = S_NBR_RD;
            OP_FIN:   state_next = S_FIN_RD;
            OP_RDPTR, OP_RDADJ: state_next = S_RD_WAIT;
            OP_STAT: begin
              rsp_valid = 1'b1;
              rsp.status = cmd.status;
            end
            default: ;
          endcase
        end
      end
      S_NBR_RD: begin
        // ptr_q holds the neighbour's row end. Re-reading the same address keeps the
        // old value in ptr_q for the upper slot write in the next cycle.
        ptr_ra = PA'(cur.neighbor - 11'd1);
        if (slot > 15'(MAX_ENTRIES)) begin
          rsp_valid = 1'b1;
          rsp.status = ST_OVF;
          ovf_undo = 1'b1;
          state_next = S_IDLE;
        end else begin
          ptr_we = 1'b1; ptr_wa = PA'(cur.neighbor - 11'd1); ptr_wd = slot[13:0];
          if (fill_position != '0 && fill_position <= 14'(MAX_ENTRIES)) begin
            adj_we = 1'b1; adj_wa = AA'(fill_position - 14'd1); adj_wd = cur.neighbor;
          end
          state_next = S_NBR_WR;
        end
      end
      S_NBR_WR: begin
        adj_we2 = 1'b1; adj_wa2 = AA'(ptr_q); adj_wd2 = current_node;
        state_next = S_IDLE;
      end
      S_FIN_RD: begin
        ptr_ra = PA'(k - 11'd1);
        state_next = S_FIN_WR;
      end
      S_FIN_WR: begin
        ptr_we = 1'b1;
        ptr_wa = k;
        ptr_wd = ptr_q + 14'd1;
        if (k == 11'd0) begin
          ptr_wd = 14'd1;
          rsp_valid = 1'b1;
          rsp.status = ST_DONE;
          state_next = S_IDLE;
        end else begin
          state_next = S_FIN_RD;
        end
      end
      S_RD_WAIT: begin
        rsp_valid = 1'b1;
        rsp.status = ST_DATA;
        rsp.value = rd_is_ptr ? ptr_q : {3'd0, adj_q};
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/lower_to_full_adjacency_builder.sv
// Top level of the lower-to-full adjacency builder: front, command queue, back.
// Depends on ladj_pkg, ladj_front and ladj_back.
// Items are handled one at a time. After an item is accepted busy stays high until
// the back end is done with it. A status-only item or node record needs no further
// state; a read waits for the memory; a neighbour goes through a pointer read, a
// pointer and row write and an upper slot write (the writes are skipped if it
// overflows); finish walks the pointer memory through its one port. A one-entry
// queue sits between the classifier and the executor. Each result appears for one
// cycle on value/status with done high and cannot be held off. Internally the
// pointer memory is addressed zero-based.
module lower_to_full_adjacency_builder import ladj_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  output logic        done,
  output rsp_t        rsp
);

  logic [10:0] node_count;
  cmd_t cmd_f, q0, q1;
  logic [1:0] cnt;
  logic take, cmd_take, ovf_undo;
  logic pend;
  logic back_idle;

  always_ff @(posedge clk) begin
    if (rst) node_count <= '0;
    else if (cfg_we) node_count <= cfg_data;
  end

  assign busy = cnt[1] || pend;
  assign take = start && !busy;

  // Neighbour classification depends on whether an earlier one overflowed, so
  // every transaction waits until the back end has drained.
  assign pend = (cnt != 2'd0) || !back_idle;

  ladj_front u_front (.clk, .rst, .take, .req, .node_count, .dec_undo(ovf_undo),
                      .cmd(cmd_f));

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (take) cnt <= 2'd1;
    else if (cmd_take) cnt <= 2'd0;
    if (take) q0 <= cmd_f;
  end
  assign q1 = q0;

  ladj_back u_back (.clk, .rst, .cmd_valid(cnt != 2'd0), .cmd(q1), .node_count,
                    .cmd_take, .rsp_valid(done), .rsp, .ovf_undo, .idle(back_idle));

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd0 |-> busy) else $error("accept while queued");
  a_done_status: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_DATA |-> rsp.value == '0) else $error("status value");

endmodule

>>> verif/tb_lower_to_full_adjacency_builder.sv
// Self-checking testbench for lower_to_full_adjacency_builder: builds one graph and reads it back.
// Depends on ladj_pkg and the RTL in hw/rtl; a local predictor supplies every expected response.
`timescale 1ns / 1ps

module tb_lower_to_full_adjacency_builder;
  import ladj_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 20000;

  typedef struct {
    req_t req;
    bit   has_rsp;
    rsp_t rsp;
  } txn_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        done;
  rsp_t        rsp;

  lower_to_full_adjacency_builder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow of the builder's state.
  int  row_ptr [0:MAX_NODES+1];
  int  adj_mem [1:MAX_ENTRIES];
  bit  adj_known [1:MAX_ENTRIES];
  int  adj_known_q [$];
  int  row_start, fill_pos, cur_node, nbrs_left, node_cfg;
  bit  graph_built;

  txn_t pending_q [$];
  txn_t in_flight;
  rsp_t expected_q [$];
  int   n_issued = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  int   stall_cnt = 0;

  function automatic bit predict_response(input req_t r, output rsp_t e);
    int n, slot;
    n = (node_cfg > MAX_NODES) ? MAX_NODES : node_cfg;
    e = '{value: '0, status: ST_ERR};
    case (r.req_type)
      REQ_NODE: begin
        if (n == 0 || graph_built || nbrs_left != 0 || cur_node >= n) return 1;
        if (r.lower_degree > r.total_degree) return 1;
        if (row_start + r.total_degree > MAX_ENTRIES + 1) begin
          e.status = ST_OVF;
          return 1;
        end
        cur_node++;
        // Row end before any upper-slot fills land in it.
        row_ptr[cur_node] = row_start + r.lower_degree - 1;
        fill_pos = row_start;
        nbrs_left = r.lower_degree;
        row_start += r.total_degree;
        return 0;
      end
      REQ_NBR: begin
        if (nbrs_left == 0 || r.neighbor < 1 || r.neighbor >= cur_node) return 1;
        slot = row_ptr[r.neighbor] + 1;
        if (slot > MAX_ENTRIES) begin
          e.status = ST_OVF;
          return 1;
        end
        if (fill_pos >= 1 && fill_pos <= MAX_ENTRIES) begin
          adj_mem[fill_pos] = r.neighbor;
          if (!adj_known[fill_pos]) adj_known_q.push_back(fill_pos);
          adj_known[fill_pos] = 1'b1;
        end
        fill_pos++;
        row_ptr[r.neighbor] = slot;
        adj_mem[slot] = cur_node;
        if (!adj_known[slot]) adj_known_q.push_back(slot);
        adj_known[slot] = 1'b1;
        nbrs_left--;
        return 0;
      end
      REQ_FIN: begin
        if (n == 0) begin
          e.status = ST_DONE;
          return 1;
        end
        if (graph_built || cur_node != n || nbrs_left != 0) return 1;
        for (int k = n + 1; k >= 2; k--) row_ptr[k] = row_ptr[k-1] + 1;
        row_ptr[1] = 1;
        graph_built = 1'b1;
        e.status = ST_DONE;
        return 1;
      end
      REQ_RDPTR: begin
        if (r.index < 1 || r.index > MAX_NODES + 1) return 1;
        e = '{value: row_ptr[r.index][13:0], status: ST_DATA};
        return 1;
      end
      REQ_RDADJ: begin
        if (r.index < 1 || r.index > MAX_ENTRIES) return 1;
        e = '{value: adj_mem[r.index][13:0], status: ST_DATA};
        return 1;
      end
      default: return 1;
    endcase
  endfunction

  task automatic queue_req(input logic [2:0] op, input int lower, input int total,
                           input int nb, input int idx);
    txn_t t;
    t.req = '{req_type: op, lower_degree: lower[9:0], total_degree: total[9:0],
              neighbor: nb[10:0], index: idx[13:0]};
    t.has_rsp = predict_response(t.req, t.rsp);
    pending_q.push_back(t);
  endtask

  task automatic drain();
    do @(negedge clk); while (pending_q.size() != 0 || start || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_node_count(input int v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[10:0];
    node_cfg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Valid reads only touch entries that the builder has already written.
  task automatic queue_valid_read();
    int hi;
    hi = graph_built ? (cur_node + 1) : cur_node;
    if (($urandom_range(1) == 0 || adj_known_q.size() == 0) && hi > 0)
      queue_req(REQ_RDPTR, $urandom, $urandom, $urandom, $urandom_range(1, hi));
    else if (adj_known_q.size() != 0)
      queue_req(REQ_RDADJ, $urandom, $urandom, $urandom,
                adj_known_q[$urandom_range(adj_known_q.size() - 1)]);
  endtask

  task automatic queue_noise();
    case ($urandom_range(7))
      0: queue_req(REQ_NBR, 0, 0, $urandom_range(1) ? 0 : cur_node, 0);
      1: queue_req(REQ_NBR, $urandom, $urandom, $urandom_range(1024, 2047), $urandom);
      2: queue_req(REQ_NODE, $urandom_range(512, 1023), $urandom_range(0, 511), 0, 0);
      3: queue_req(REQ_FIN, $urandom, $urandom, $urandom, $urandom);
      4: queue_req(REQ_RDPTR, 0, 0, 0, $urandom_range(1) ? 0 : $urandom_range(1026, 16383));
      5: queue_req(REQ_RDADJ, 0, 0, 0, $urandom_range(1) ? 0 : $urandom_range(8193, 16383));
      6: queue_req(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
      default: queue_valid_read();
    endcase
  endtask

  // Driver: a new transaction is presented only after the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (n_sent == n_issued) begin
      if (pending_q.size() != 0 &&
          !((n_sent < 300 || n_sent > 550) && $urandom_range(99) < 7)) begin
        in_flight = pending_q.pop_front();
        req <= in_flight.req;
        start <= 1'b1;
        n_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check the response strobe, then record the accepted transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("response with no transaction outstanding: value %0d status %0d",
                 rsp.value, rsp.status);
          n_errors++;
        end else begin
          rsp_t e;
          e = expected_q.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            n_errors++;
          end
          if (rsp.value !== e.value) begin
            $error("value: expected %0d, got %0d", e.value, rsp.value);
            n_errors++;
          end
          n_checked++;
        end
      end
      if (start && !busy) begin
        n_sent++;
        if (in_flight.has_rsp) expected_q.push_back(in_flight.rsp);
      end
      stall_cnt = ((start && !busy) || done) ? 0 : stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int lower, total, tries;
    row_start = 1; fill_pos = 1; cur_node = 0; nbrs_left = 0; node_cfg = 0;
    graph_built = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With no nodes configured nothing is built and finish reports done at once.
    set_node_count(0);
    queue_req(REQ_NODE, 0, 0, 0, 0);
    queue_req(REQ_NBR, 0, 0, 2047, 0);
    queue_req(REQ_FIN, 0, 0, 0, 0);
    queue_req(REQ_RDPTR, 0, 0, 0, 0);
    queue_req(REQ_RDPTR, 0, 0, 0, 1026);
    queue_req(REQ_RDPTR, 0, 0, 0, 16383);
    queue_req(REQ_RDADJ, 0, 0, 0, 0);
    queue_req(REQ_RDADJ, 0, 0, 0, 8193);
    for (int k = 5; k <= 7; k++) queue_req(3'(k), 1023, 1023, 2047, 16383);

    // An oversized count is clamped to MAX_NODES; build part of the graph under it.
    set_node_count(2047);
    queue_req(REQ_NBR, 0, 0, 1, 0);
    queue_req(REQ_NODE, 1023, 0, 0, 0);
    queue_req(REQ_NODE, 0, 3, 0, 0);
    queue_req(REQ_FIN, 0, 0, 0, 0);
    queue_req(REQ_NODE, 1, 2, 0, 0);
    queue_req(REQ_NODE, 0, 1, 0, 0);
    queue_req(REQ_NBR, 0, 0, 2, 0);
    queue_req(REQ_NBR, 0, 0, 1, 0);
    queue_req(REQ_RDPTR, 0, 0, 0, 2);
    queue_req(REQ_RDADJ, 0, 0, 0, 4);

    while (pending_q.size() < 640 && cur_node < 1000) begin
      if ($urandom_range(99) < 10) begin
        queue_noise();
      end else begin
        lower = $urandom_range(0, cur_node < 6 ? cur_node : 6);
        case ($urandom_range(99)) inside
          [0:29]:  total = lower;
          [30:37]: total = $urandom_range(512, 1023);
          default: total = lower + $urandom_range(0, 8);
        endcase
        queue_req(REQ_NODE, lower, total, 0, 0);
        tries = 0;
        while (nbrs_left != 0 && tries < lower + 4) begin
          // Recent nodes are picked often so their upper slots spill and overflow.
          queue_req(REQ_NBR, $urandom, $urandom,
                    $urandom_range(1) ? $urandom_range(1, cur_node - 1)
                                      : $urandom_range(cur_node > 4 ? cur_node - 4 : 1,
                                                       cur_node - 1), $urandom);
          tries++;
        end
      end
    end

    // Close the graph at exactly the nodes received, then read it back.
    set_node_count(cur_node);
    queue_req(REQ_FIN, 0, 0, 0, 0);
    queue_req(REQ_FIN, 0, 0, 0, 0);
    queue_req(REQ_RDPTR, 0, 0, 0, cur_node + 1);
    repeat (300) begin
      if ($urandom_range(99) < 10) queue_noise();
      else queue_valid_read();
    end

    set_node_count(MAX_NODES);
    queue_req(REQ_FIN, 0, 0, 0, 0);
    queue_req(REQ_NODE, 0, 0, 0, 0);
    repeat (40) queue_valid_read();

    set_node_count(0);
    queue_req(REQ_FIN, 0, 0, 0, 0);
    repeat (20) queue_valid_read();
    drain();

    $display("Sent %0d transactions and checked %0d responses; built %0d nodes into %0d entries.",
             n_sent, n_checked, cur_node, row_start - 1);
    $display("Node counts covered: 0, 2047, %0d and %0d; %0d mismatches.",
             cur_node, MAX_NODES, n_errors);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ladj_pkg.sv
hw/rtl/ladj_front.sv
hw/rtl/ladj_back.sv
hw/rtl/lower_to_full_adjacency_builder.sv
verif/tb_lower_to_full_adjacency_builder.sv
